// ===== sv/rpmm_pkg.sv =====
// rpmm_pkg: shared widths, register reset values, csr index codes and pipeline control type
// for the rate pid motor mixer; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package rpmm_pkg;

   localparam int unsigned NUM_AXES = 3;
   localparam int unsigned DATA_W   = 16;  // q8.8 fields and gains
   localparam int unsigned LIM_W    = 15;  // symmetric limits
   localparam int unsigned ERR_W    = 17;  // target minus measured, exact
   localparam int unsigned DIFF_W   = 18;  // error minus previous error
   localparam int unsigned PROD_W   = 34;  // 17 x 17 signed product
   localparam int unsigned SUM_W    = 35;  // sum of the three q16.16 terms
   localparam int unsigned RND_W    = SUM_W - 8;
   localparam int unsigned MIX_W    = 19;  // thrust plus three torques
   localparam int unsigned IDX_W    = 3;

   // derivative gain, unsigned q8.8, fixed at build time
   localparam logic [DATA_W-1:0] KD_GAIN = 16'd0;

   localparam logic [DATA_W-1:0] KP_RP_RST    = 16'd3840;
   localparam logic [DATA_W-1:0] KI_RP_RST    = 16'd51;
   localparam logic [DATA_W-1:0] KP_YAW_RST   = 16'd5120;
   localparam logic [DATA_W-1:0] KI_YAW_RST   = 16'd77;
   localparam logic [LIM_W-1:0]  INT_LIM_RST  = 15'd768;
   localparam logic [LIM_W-1:0]  TRQ_LIM_RST  = 15'd1280;
   localparam logic [DATA_W-1:0] FLOOR_RST    = 16'd0;
   localparam logic [DATA_W-1:0] CEILING_RST  = 16'd65535;

   typedef enum logic [IDX_W-1:0] {
      CSR_KP_RP    = 3'd0,
      CSR_KI_RP    = 3'd1,
      CSR_KP_YAW   = 3'd2,
      CSR_KI_YAW   = 3'd3,
      CSR_INT_LIM  = 3'd4,
      CSR_TRQ_LIM  = 3'd5,
      CSR_FLOOR    = 3'd6,
      CSR_CEILING  = 3'd7
   } csr_index_type;

   // per-stage load strobes, one per stage boundary from the input register to the torque stage
   typedef struct packed {
      logic load_b;   // input register into error / integral stage
      logic load_c;   // error stage into product stage
      logic load_d;   // product stage into torque stage
   } pipe_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/rpmm_integ.sv =====
// rpmm_integ: per-axis error, clamped integral and derivative difference, with the
// integral and previous error state; depends on rpmm_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpmm_integ (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire rpmm_pkg::pipe_ctrl_type                 ctrl,
   input  wire logic signed [rpmm_pkg::DATA_W-1:0]      target   [rpmm_pkg::NUM_AXES],
   input  wire logic signed [rpmm_pkg::DATA_W-1:0]      meas     [rpmm_pkg::NUM_AXES],
   input  wire logic        [rpmm_pkg::LIM_W-1:0]       int_limit,
   output logic signed      [rpmm_pkg::ERR_W-1:0]       err_ff   [rpmm_pkg::NUM_AXES],
   output logic signed      [rpmm_pkg::ERR_W-1:0]       acc_ff   [rpmm_pkg::NUM_AXES],
   output logic signed      [rpmm_pkg::DIFF_W-1:0]      diff_ff  [rpmm_pkg::NUM_AXES]
);

   logic signed [rpmm_pkg::ERR_W-1:0] integ_ff [rpmm_pkg::NUM_AXES];
   logic signed [rpmm_pkg::ERR_W-1:0] prev_ff  [rpmm_pkg::NUM_AXES];
   logic signed [rpmm_pkg::ERR_W-1:0] err_in   [rpmm_pkg::NUM_AXES];
   logic signed [rpmm_pkg::ERR_W-1:0] acc_in   [rpmm_pkg::NUM_AXES];
   logic signed [rpmm_pkg::DIFF_W-1:0] diff_in [rpmm_pkg::NUM_AXES];

   logic signed [rpmm_pkg::DIFF_W-1:0] lim_pos;
   logic signed [rpmm_pkg::DIFF_W-1:0] lim_neg;

   assign lim_pos = $signed({3'b000, int_limit});
   assign lim_neg = -lim_pos;

   for (genvar ax = 0; ax < rpmm_pkg::NUM_AXES; ax++) begin : g_axis
      logic signed [rpmm_pkg::DIFF_W-1:0] sum;

      assign err_in[ax]  = $signed({target[ax][rpmm_pkg::DATA_W-1], target[ax]})
                         - $signed({meas[ax][rpmm_pkg::DATA_W-1], meas[ax]});
      assign sum         = $signed({integ_ff[ax][rpmm_pkg::ERR_W-1], integ_ff[ax]})
                         + $signed({err_in[ax][rpmm_pkg::ERR_W-1], err_in[ax]});
      assign acc_in[ax]  = (sum > lim_pos) ? lim_pos[rpmm_pkg::ERR_W-1:0] :
                           (sum < lim_neg) ? lim_neg[rpmm_pkg::ERR_W-1:0] :
                                             sum[rpmm_pkg::ERR_W-1:0];
      assign diff_in[ax] = $signed({err_in[ax][rpmm_pkg::ERR_W-1], err_in[ax]})
                         - $signed({prev_ff[ax][rpmm_pkg::ERR_W-1], prev_ff[ax]});

      // controller state moves on once per transfer into this stage
      always_ff @(posedge clock) begin
         if (reset) begin
            integ_ff[ax] <= '0;
            prev_ff[ax]  <= '0;
         end else if (ctrl.load_b) begin
            integ_ff[ax] <= acc_in[ax];
            prev_ff[ax]  <= err_in[ax];
         end
      end

      always_ff @(posedge clock) begin
         if (ctrl.load_b) begin
            err_ff[ax]  <= err_in[ax];
            acc_ff[ax]  <= acc_in[ax];
            diff_ff[ax] <= diff_in[ax];
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/rpmm_axis_pid.sv =====
// rpmm_axis_pid: one axis controller, gain products then rounding and torque clamp,
// two register stages; depends on rpmm_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpmm_axis_pid (
   input  wire                                       clock,
   input  wire rpmm_pkg::pipe_ctrl_type              ctrl,
   input  wire logic        [rpmm_pkg::DATA_W-1:0]   kp,
   input  wire logic        [rpmm_pkg::DATA_W-1:0]   ki,
   input  wire logic        [rpmm_pkg::LIM_W-1:0]    torque_limit,
   input  wire logic signed [rpmm_pkg::ERR_W-1:0]    err,
   input  wire logic signed [rpmm_pkg::ERR_W-1:0]    acc,
   input  wire logic signed [rpmm_pkg::DIFF_W-1:0]   diff,
   output logic signed      [rpmm_pkg::DATA_W-1:0]   torque_ff
);

   logic signed [rpmm_pkg::PROD_W-1:0] kp_prod_in, kp_prod_ff;
   logic signed [rpmm_pkg::PROD_W-1:0] ki_prod_in, ki_prod_ff;
   logic signed [rpmm_pkg::SUM_W-1:0]  kd_prod_in, kd_prod_ff;
   logic signed [rpmm_pkg::SUM_W-1:0]  sum;
   logic signed [rpmm_pkg::SUM_W-1:0]  biased;
   logic signed [rpmm_pkg::RND_W-1:0]  rounded;
   logic signed [rpmm_pkg::RND_W-1:0]  lim_pos;
   logic signed [rpmm_pkg::RND_W-1:0]  lim_neg;
   logic signed [rpmm_pkg::DATA_W-1:0] torque_in;

   assign kp_prod_in = $signed({1'b0, kp}) * err;
   assign ki_prod_in = $signed({1'b0, ki}) * acc;
   assign kd_prod_in = $signed({1'b0, rpmm_pkg::KD_GAIN}) * diff;

   always_ff @(posedge clock) begin
      if (ctrl.load_c) begin
         kp_prod_ff <= kp_prod_in;
         ki_prod_ff <= ki_prod_in;
         kd_prod_ff <= kd_prod_in;
      end
   end

   // q16.16 sum, round half up to q8.8
   assign sum     = $signed({kp_prod_ff[rpmm_pkg::PROD_W-1], kp_prod_ff})
                  + $signed({ki_prod_ff[rpmm_pkg::PROD_W-1], ki_prod_ff})
                  + kd_prod_ff;
   assign biased  = sum + 35'sd128;
   assign rounded = biased[rpmm_pkg::SUM_W-1:8];

   assign lim_pos = $signed({{(rpmm_pkg::RND_W-rpmm_pkg::LIM_W){1'b0}}, torque_limit});
   assign lim_neg = -lim_pos;

   assign torque_in = (rounded > lim_pos) ? lim_pos[rpmm_pkg::DATA_W-1:0] :
                      (rounded < lim_neg) ? lim_neg[rpmm_pkg::DATA_W-1:0] :
                                            rounded[rpmm_pkg::DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.load_d) begin
         torque_ff <= torque_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/rpmm_mixer.sv =====
// rpmm_mixer: x-frame mixing of thrust and three torques into four clamped motor thrusts;
// depends on rpmm_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpmm_mixer (
   input  wire logic        [rpmm_pkg::DATA_W-1:0] thrust,
   input  wire logic signed [rpmm_pkg::DATA_W-1:0] tx,
   input  wire logic signed [rpmm_pkg::DATA_W-1:0] ty,
   input  wire logic signed [rpmm_pkg::DATA_W-1:0] tz,
   input  wire logic        [rpmm_pkg::DATA_W-1:0] thrust_floor,
   input  wire logic        [rpmm_pkg::DATA_W-1:0] thrust_ceiling,
   output logic             [rpmm_pkg::DATA_W-1:0] motor_one,
   output logic             [rpmm_pkg::DATA_W-1:0] motor_two,
   output logic             [rpmm_pkg::DATA_W-1:0] motor_three,
   output logic             [rpmm_pkg::DATA_W-1:0] motor_four
);

   localparam int unsigned EXT_W = rpmm_pkg::MIX_W - rpmm_pkg::DATA_W;

   logic signed [rpmm_pkg::MIX_W-1:0] t_ext, x_ext, y_ext, z_ext;
   logic signed [rpmm_pkg::MIX_W-1:0] lo, hi;
   logic signed [rpmm_pkg::MIX_W-1:0] m1, m2, m3, m4;

   // floor first, ceiling second: a ceiling under the floor wins
   function automatic logic [rpmm_pkg::DATA_W-1:0] clamp_motor(
      input logic signed [rpmm_pkg::MIX_W-1:0] v,
      input logic signed [rpmm_pkg::MIX_W-1:0] vlo,
      input logic signed [rpmm_pkg::MIX_W-1:0] vhi
   );
      logic signed [rpmm_pkg::MIX_W-1:0] r;
      r = (v < vlo) ? vlo : v;
      r = (r > vhi) ? vhi : r;
      return r[rpmm_pkg::DATA_W-1:0];
   endfunction

   assign t_ext = $signed({{EXT_W{1'b0}}, thrust});
   assign x_ext = $signed({{EXT_W{tx[rpmm_pkg::DATA_W-1]}}, tx});
   assign y_ext = $signed({{EXT_W{ty[rpmm_pkg::DATA_W-1]}}, ty});
   assign z_ext = $signed({{EXT_W{tz[rpmm_pkg::DATA_W-1]}}, tz});
   assign lo    = $signed({{EXT_W{1'b0}}, thrust_floor});
   assign hi    = $signed({{EXT_W{1'b0}}, thrust_ceiling});

   assign m1 = t_ext + x_ext + y_ext - z_ext;
   assign m2 = t_ext - x_ext - y_ext - z_ext;
   assign m3 = t_ext - x_ext + y_ext + z_ext;
   assign m4 = t_ext + x_ext - y_ext + z_ext;

   assign motor_one   = clamp_motor(m1, lo, hi);
   assign motor_two   = clamp_motor(m2, lo, hi);
   assign motor_three = clamp_motor(m3, lo, hi);
   assign motor_four  = clamp_motor(m4, lo, hi);

endmodule

`default_nettype wire

// ===== sv/rate_pid_motor_mixer_unit.sv =====
// rate_pid_motor_mixer_unit: top level, csr bank, pipeline control and result register
// depends on rpmm_pkg, rpmm_integ, rpmm_axis_pid, rpmm_mixer
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     thrust, three rate targets, three measured rates
//   rsp      out        rsp_valid / rsp_ready     four motor thrusts
//   csr      in         csr_valid / csr_ready     csr_index, csr_wdata
//
// one transfer in and one out per cycle sustained while rsp_ready stays high; from the req
// transfer to rsp_valid a tick passes input reg, error/integral, products, torque, result reg
// the integral update is the only loop and closes within the error/integral stage
// a stalled rsp backs up stage by stage; req_ready drops only when every stage is full
// synchronous reset clears stage valids, integrals and previous errors and reloads the
// csr defaults; csr_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module rate_pid_motor_mixer_unit (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire logic        [15:0]           req_collective_thrust,
   input  wire logic signed [15:0]           req_rate_target_x,
   input  wire logic signed [15:0]           req_rate_target_y,
   input  wire logic signed [15:0]           req_rate_target_z,
   input  wire logic signed [15:0]           req_rate_meas_x,
   input  wire logic signed [15:0]           req_rate_meas_y,
   input  wire logic signed [15:0]           req_rate_meas_z,
   // response channel
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic             [15:0]           rsp_motor_one,
   output logic             [15:0]           rsp_motor_two,
   output logic             [15:0]           rsp_motor_three,
   output logic             [15:0]           rsp_motor_four,
   // register write channel
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire logic        [2:0]            csr_index,
   input  wire logic        [15:0]           csr_wdata
);

   localparam int unsigned DW = rpmm_pkg::DATA_W;
   localparam int unsigned NA = rpmm_pkg::NUM_AXES;

   // ---------------- csr bank ----------------
   logic [DW-1:0]             kp_rp_ff, ki_rp_ff, kp_yaw_ff, ki_yaw_ff;
   logic [rpmm_pkg::LIM_W-1:0] int_lim_ff, trq_lim_ff;
   logic [DW-1:0]             floor_ff, ceiling_ff;
   logic                      csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_rp_ff   <= rpmm_pkg::KP_RP_RST;
         ki_rp_ff   <= rpmm_pkg::KI_RP_RST;
         kp_yaw_ff  <= rpmm_pkg::KP_YAW_RST;
         ki_yaw_ff  <= rpmm_pkg::KI_YAW_RST;
         int_lim_ff <= rpmm_pkg::INT_LIM_RST;
         trq_lim_ff <= rpmm_pkg::TRQ_LIM_RST;
         floor_ff   <= rpmm_pkg::FLOOR_RST;
         ceiling_ff <= rpmm_pkg::CEILING_RST;
      end else if (csr_write) begin
         unique case (rpmm_pkg::csr_index_type'(csr_index))
            rpmm_pkg::CSR_KP_RP:   kp_rp_ff   <= csr_wdata;
            rpmm_pkg::CSR_KI_RP:   ki_rp_ff   <= csr_wdata;
            rpmm_pkg::CSR_KP_YAW:  kp_yaw_ff  <= csr_wdata;
            rpmm_pkg::CSR_KI_YAW:  ki_yaw_ff  <= csr_wdata;
            rpmm_pkg::CSR_INT_LIM: int_lim_ff <= csr_wdata[rpmm_pkg::LIM_W-1:0];
            rpmm_pkg::CSR_TRQ_LIM: trq_lim_ff <= csr_wdata[rpmm_pkg::LIM_W-1:0];
            rpmm_pkg::CSR_FLOOR:   floor_ff   <= csr_wdata;
            rpmm_pkg::CSR_CEILING: ceiling_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // a stage loads when the one ahead is empty or is emptying this cycle
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, rsp_valid_ff;
   logic load_a, load_o;
   rpmm_pkg::pipe_ctrl_type ctrl;

   assign load_o      = d_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign ctrl.load_d = c_valid_ff && (!d_valid_ff || load_o);
   assign ctrl.load_c = b_valid_ff && (!c_valid_ff || ctrl.load_d);
   assign ctrl.load_b = a_valid_ff && (!b_valid_ff || ctrl.load_c);
   assign req_ready   = !a_valid_ff || ctrl.load_b;
   assign load_a      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_a || ctrl.load_b)      a_valid_ff   <= load_a;
         if (ctrl.load_b || ctrl.load_c) b_valid_ff   <= ctrl.load_b;
         if (ctrl.load_c || ctrl.load_d) c_valid_ff   <= ctrl.load_c;
         if (ctrl.load_d || load_o)      d_valid_ff   <= ctrl.load_d;
         if (load_o || rsp_ready)        rsp_valid_ff <= load_o;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------- input register ----------------
   logic        [DW-1:0] a_thrust_ff;
   logic signed [DW-1:0] a_target_ff [NA];
   logic signed [DW-1:0] a_meas_ff   [NA];

   always_ff @(posedge clock) begin
      if (load_a) begin
         a_thrust_ff    <= req_collective_thrust;
         a_target_ff[0] <= req_rate_target_x;
         a_target_ff[1] <= req_rate_target_y;
         a_target_ff[2] <= req_rate_target_z;
         a_meas_ff[0]   <= req_rate_meas_x;
         a_meas_ff[1]   <= req_rate_meas_y;
         a_meas_ff[2]   <= req_rate_meas_z;
      end
   end

   // thrust rides alongside the controller stages
   logic [DW-1:0] b_thrust_ff, c_thrust_ff, d_thrust_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load_b) b_thrust_ff <= a_thrust_ff;
      if (ctrl.load_c) c_thrust_ff <= b_thrust_ff;
      if (ctrl.load_d) d_thrust_ff <= c_thrust_ff;
   end

   // ---------------- error and integral stage ----------------
   logic signed [rpmm_pkg::ERR_W-1:0]  err   [NA];
   logic signed [rpmm_pkg::ERR_W-1:0]  acc   [NA];
   logic signed [rpmm_pkg::DIFF_W-1:0] diff  [NA];
   logic signed [DW-1:0]               torque [NA];

   rpmm_integ u_integ (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .target    (a_target_ff),
      .meas      (a_meas_ff),
      .int_limit (int_lim_ff),
      .err_ff    (err),
      .acc_ff    (acc),
      .diff_ff   (diff)
   );

   // ---------------- per-axis controllers ----------------
   // roll and pitch share gains, yaw has its own
   for (genvar ax = 0; ax < NA; ax++) begin : g_pid
      logic [DW-1:0] kp_sel, ki_sel;

      assign kp_sel = (ax == NA - 1) ? kp_yaw_ff : kp_rp_ff;
      assign ki_sel = (ax == NA - 1) ? ki_yaw_ff : ki_rp_ff;

      rpmm_axis_pid u_pid (
         .clock        (clock),
         .ctrl         (ctrl),
         .kp           (kp_sel),
         .ki           (ki_sel),
         .torque_limit (trq_lim_ff),
         .err          (err[ax]),
         .acc          (acc[ax]),
         .diff         (diff[ax]),
         .torque_ff    (torque[ax])
      );
   end

   // ---------------- mixer and result register ----------------
   logic [DW-1:0] motor_one, motor_two, motor_three, motor_four;
   logic [DW-1:0] rsp_motor_one_ff, rsp_motor_two_ff, rsp_motor_three_ff, rsp_motor_four_ff;

   rpmm_mixer u_mixer (
      .thrust         (d_thrust_ff),
      .tx             (torque[0]),
      .ty             (torque[1]),
      .tz             (torque[2]),
      .thrust_floor   (floor_ff),
      .thrust_ceiling (ceiling_ff),
      .motor_one      (motor_one),
      .motor_two      (motor_two),
      .motor_three    (motor_three),
      .motor_four     (motor_four)
   );

   always_ff @(posedge clock) begin
      if (load_o) begin
         rsp_motor_one_ff   <= motor_one;
         rsp_motor_two_ff   <= motor_two;
         rsp_motor_three_ff <= motor_three;
         rsp_motor_four_ff  <= motor_four;
      end
   end

   assign rsp_motor_one   = rsp_motor_one_ff;
   assign rsp_motor_two   = rsp_motor_two_ff;
   assign rsp_motor_three = rsp_motor_three_ff;
   assign rsp_motor_four  = rsp_motor_four_ff;

endmodule

`default_nettype wire

// ===== sv/rpmm_checker.sv =====
// rpmm_checker: port-level assertions on the rate pid motor mixer and the bind that
// attaches them; depends on rate_pid_motor_mixer_unit
`timescale 1ns / 1ps
`default_nettype none

module rpmm_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [15:0] rsp_motor_one,
   input wire [15:0] rsp_motor_two,
   input wire [15:0] rsp_motor_three,
   input wire [15:0] rsp_motor_four,
   input wire        csr_valid,
   input wire        csr_ready
);

   // nothing comes out straight after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // the input side only stalls when the whole pipe is full behind a stalled result
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without a stalled response");

   // register writes are never back-pressured
   a_csr_always_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write stalled");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_motor_one)
         && $stable(rsp_motor_two) && $stable(rsp_motor_three)
         && $stable(rsp_motor_four)))
      else $error("stalled response changed");

endmodule

bind rate_pid_motor_mixer_unit rpmm_checker u_rpmm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_motor_one   (rsp_motor_one),
   .rsp_motor_two   (rsp_motor_two),
   .rsp_motor_three (rsp_motor_three),
   .rsp_motor_four  (rsp_motor_four),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready)
);

`default_nettype wire

// ===== tb/rate_pid_motor_mixer_unit_tb.sv =====
// self-checking bench for rate_pid_motor_mixer_unit: per-axis pi-d rates into the quad-x mixer
// depends on rpmm_pkg and the unit under test; holds its own predictor of the control law
`timescale 1ns / 1ps

module rate_pid_motor_mixer_unit_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 10;    // margin for the pipeline to empty
   localparam int ITEMS_PER_PH = 165;
   localparam int NUM_PROFILES = 8;

   // one control tick as offered on the request channel
   typedef struct packed {
      logic        [15:0] thrust;
      logic signed [15:0] tgt_x;
      logic signed [15:0] tgt_y;
      logic signed [15:0] tgt_z;
      logic signed [15:0] meas_x;
      logic signed [15:0] meas_y;
      logic signed [15:0] meas_z;
   } rate_cmd_type;

   // the four motor thrusts of one response
   typedef struct packed {
      logic [15:0] motor_one;
      logic [15:0] motor_two;
      logic [15:0] motor_three;
      logic [15:0] motor_four;
   } motor_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic       [15:0] req_collective_thrust = '0;
   logic signed [15:0] req_rate_target_x = '0;
   logic signed [15:0] req_rate_target_y = '0;
   logic signed [15:0] req_rate_target_z = '0;
   logic signed [15:0] req_rate_meas_x = '0;
   logic signed [15:0] req_rate_meas_y = '0;
   logic signed [15:0] req_rate_meas_z = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic       [15:0] rsp_motor_one;
   logic       [15:0] rsp_motor_two;
   logic       [15:0] rsp_motor_three;
   logic       [15:0] rsp_motor_four;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic        [2:0] csr_index = '0;
   logic       [15:0] csr_wdata = '0;

   rate_pid_motor_mixer_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_collective_thrust (req_collective_thrust),
      .req_rate_target_x     (req_rate_target_x),
      .req_rate_target_y     (req_rate_target_y),
      .req_rate_target_z     (req_rate_target_z),
      .req_rate_meas_x       (req_rate_meas_x),
      .req_rate_meas_y       (req_rate_meas_y),
      .req_rate_meas_z       (req_rate_meas_z),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_motor_one         (rsp_motor_one),
      .rsp_motor_two         (rsp_motor_two),
      .rsp_motor_three       (rsp_motor_three),
      .rsp_motor_four        (rsp_motor_four),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // predictor: register shadow copies and the controller state they act on
   // ---------------------------------------------------------------------------------------
   int cfg_kp_rp   = int'(rpmm_pkg::KP_RP_RST);
   int cfg_ki_rp   = int'(rpmm_pkg::KI_RP_RST);
   int cfg_kp_yaw  = int'(rpmm_pkg::KP_YAW_RST);
   int cfg_ki_yaw  = int'(rpmm_pkg::KI_YAW_RST);
   int cfg_int_lim = int'(rpmm_pkg::INT_LIM_RST);
   int cfg_trq_lim = int'(rpmm_pkg::TRQ_LIM_RST);
   int cfg_floor   = int'(rpmm_pkg::FLOOR_RST);
   int cfg_ceiling = int'(rpmm_pkg::CEILING_RST);

   int axis_integral [3];   // clamped error sums, zero after reset
   int axis_prev_err [3];   // last error per axis, feeds the derivative term

   // floor first, then ceiling: a floor above the ceiling leaves every motor at the ceiling
   function automatic logic [15:0] clip_motor(int v);
      if (v < cfg_floor) v = cfg_floor;
      if (v > cfg_ceiling) v = cfg_ceiling;
      return 16'(v);
   endfunction

   // advances the three axis controllers by one tick and mixes the torques
   function automatic motor_set_type predict_motors(rate_cmd_type c);
      int            err [3];
      int            trq [3];
      int            kp;
      int            ki;
      int            thr;
      longint        acc;
      longint        sum;
      motor_set_type m;
      err[0] = int'($signed(c.tgt_x)) - int'($signed(c.meas_x));
      err[1] = int'($signed(c.tgt_y)) - int'($signed(c.meas_y));
      err[2] = int'($signed(c.tgt_z)) - int'($signed(c.meas_z));
      for (int a = 0; a < 3; a++) begin
         kp = (a == 2) ? cfg_kp_yaw : cfg_kp_rp;
         ki = (a == 2) ? cfg_ki_yaw : cfg_ki_rp;
         // integral saturates symmetrically before it is used
         acc = longint'(axis_integral[a]) + err[a];
         if (acc > cfg_int_lim) acc = cfg_int_lim;
         else if (acc < -cfg_int_lim) acc = -cfg_int_lim;
         axis_integral[a] = int'(acc);
         // q16.16 sum, then round half upwards back to q8.8
         sum = longint'(kp) * err[a] + longint'(ki) * acc
             + longint'(rpmm_pkg::KD_GAIN) * (err[a] - axis_prev_err[a]);
         axis_prev_err[a] = err[a];
         sum = (sum + 128) >>> 8;
         if (sum > cfg_trq_lim) sum = cfg_trq_lim;
         else if (sum < -cfg_trq_lim) sum = -cfg_trq_lim;
         trq[a] = int'(sum);
      end
      thr = int'(c.thrust);
      m.motor_one   = clip_motor(thr + trq[0] + trq[1] - trq[2]);
      m.motor_two   = clip_motor(thr - trq[0] - trq[1] - trq[2]);
      m.motor_three = clip_motor(thr - trq[0] + trq[1] + trq[2]);
      m.motor_four  = clip_motor(thr + trq[0] - trq[1] + trq[2]);
      return m;
   endfunction

   // ---------------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------------
   function automatic rate_cmd_type mk_cmd(logic [15:0] t, logic [15:0] tx, logic [15:0] ty,
                                           logic [15:0] tz, logic [15:0] mx, logic [15:0] my,
                                           logic [15:0] mz);
      rate_cmd_type c;
      c.thrust = t;
      c.tgt_x  = tx;
      c.tgt_y  = ty;
      c.tgt_z  = tz;
      c.meas_x = mx;
      c.meas_y = my;
      c.meas_z = mz;
      return c;
   endfunction

   // uniform in [-m, m]
   function automatic logic [15:0] near(int m);
      return 16'(int'($urandom_range(0, 2 * m)) - m);
   endfunction

   function automatic logic [15:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'hffff;
      endcase
   endfunction

   // mostly flyable ticks (tracking errors, sustained offsets), the rest noise and corners
   function automatic rate_cmd_type draw_cmd();
      rate_cmd_type c;
      int           style;
      style = $urandom_range(0, 9);
      if (style <= 3) begin
         // hover-like: measurements track modest setpoints
         c.thrust = 16'($urandom_range(8192, 57344));
         c.tgt_x  = near(1024);
         c.tgt_y  = near(1024);
         c.tgt_z  = near(1024);
         c.meas_x = c.tgt_x + $signed(near(256));
         c.meas_y = c.tgt_y + $signed(near(256));
         c.meas_z = c.tgt_z + $signed(near(256));
      end else if (style <= 5) begin
         c = mk_cmd(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
      end else if (style == 6) begin
         c = mk_cmd(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                    pick_extreme(), pick_extreme(), pick_extreme());
      end else begin
         // larger offsets that walk the integrals into their limits
         c = mk_cmd(16'($urandom), near(4096), near(4096), near(4096),
                    near(4096), near(4096), near(4096));
      end
      return c;
   endfunction

   // ---------------------------------------------------------------------------------------
   // request driver: pops pending ticks, holds each until its transfer, random gaps between
   // ---------------------------------------------------------------------------------------
   rate_cmd_type  pending_cmds [$];
   motor_set_type expected_motors [$];
   rate_cmd_type  drv_cmd;
   int            drv_gap = 0;
   bit            drv_calm = 1'b0;
   int            n_queued = 0;
   int            n_accepted = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         drv_gap = 0;
      end else begin
         // a transfer at this edge: predict from the state the block saw
         if (req_valid && req_ready) begin
            expected_motors.push_back(predict_motors(drv_cmd));
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (drv_gap > 0) begin
               drv_gap--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               drv_cmd = pending_cmds.pop_front();
               req_collective_thrust <= drv_cmd.thrust;
               req_rate_target_x     <= drv_cmd.tgt_x;
               req_rate_target_y     <= drv_cmd.tgt_y;
               req_rate_target_z     <= drv_cmd.tgt_z;
               req_rate_meas_x       <= drv_cmd.meas_x;
               req_rate_meas_y       <= drv_cmd.meas_y;
               req_rate_meas_z       <= drv_cmd.meas_z;
               req_valid <= 1'b1;
               // occasional switch into or out of back-to-back stretches
               if ($urandom_range(0, 39) == 0) drv_calm = !drv_calm;
               drv_gap = drv_calm ? 0 : $urandom_range(0, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // response monitor: random back-pressure, in-order comparison against the predictions
   // ---------------------------------------------------------------------------------------
   int mon_stall = 0;
   bit mon_calm = 1'b0;
   int n_checked = 0;
   int n_mismatch = 0;

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         n_mismatch++;
         if (n_mismatch <= 10)
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     n_checked, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         mon_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_motors.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("response transfer with no request outstanding");
            end else begin
               motor_set_type want;
               want = expected_motors.pop_front();
               check_field("motor_one",   want.motor_one,   rsp_motor_one);
               check_field("motor_two",   want.motor_two,   rsp_motor_two);
               check_field("motor_three", want.motor_three, rsp_motor_three);
               check_field("motor_four",  want.motor_four,  rsp_motor_four);
               n_checked++;
            end
            if ($urandom_range(0, 39) == 0) mon_calm = !mon_calm;
            mon_stall = mon_calm ? 0 : $urandom_range(0, 6);
         end else if (!rsp_ready && mon_stall > 0) begin
            mon_stall--;
         end
         rsp_ready <= (mon_stall == 0);
      end
   end

   // ---------------------------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------------------------
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out with %0d results still outstanding", expected_motors.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // register writes and phase sequencing
   // ---------------------------------------------------------------------------------------

   // one csr transfer; the shadow copy changes at the accepting edge
   task automatic write_reg(rpmm_pkg::csr_index_type idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rpmm_pkg::CSR_KP_RP:   cfg_kp_rp   = int'(val);
         rpmm_pkg::CSR_KI_RP:   cfg_ki_rp   = int'(val);
         rpmm_pkg::CSR_KP_YAW:  cfg_kp_yaw  = int'(val);
         rpmm_pkg::CSR_KI_YAW:  cfg_ki_yaw  = int'(val);
         rpmm_pkg::CSR_INT_LIM: cfg_int_lim = int'(val[14:0]);
         rpmm_pkg::CSR_TRQ_LIM: cfg_trq_lim = int'(val[14:0]);
         rpmm_pkg::CSR_FLOOR:   cfg_floor   = int'(val);
         rpmm_pkg::CSR_CEILING: cfg_ceiling = int'(val);
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // every register is rewritten at the start of each phase
   task automatic load_profile(int p);
      logic [15:0] kp_rp, ki_rp, kp_y, ki_y, ilim, tlim, lo_thr, hi_thr;
      case (p)
         0: begin   // gentle gains, limits wide open
            {kp_rp, ki_rp, kp_y, ki_y} = {16'd256, 16'd128, 16'd512, 16'd64};
            {ilim, tlim, lo_thr, hi_thr} = {16'h7fff, 16'h7fff, 16'd0, 16'hffff};
         end
         1: begin   // every gain at its top
            {kp_rp, ki_rp, kp_y, ki_y} = {16'hffff, 16'hffff, 16'hffff, 16'hffff};
            {ilim, tlim, lo_thr, hi_thr} = {16'h7fff, 16'h7fff, 16'd0, 16'hffff};
         end
         2: begin   // gains and limits at zero: motors follow the thrust
            {kp_rp, ki_rp, kp_y, ki_y} = {16'd0, 16'd0, 16'd0, 16'd0};
            {ilim, tlim, lo_thr, hi_thr} = {16'd0, 16'd0, 16'd0, 16'hffff};
         end
         3: begin   // floor above ceiling
            {kp_rp, ki_rp, kp_y, ki_y} = {16'd3840, 16'd51, 16'd5120, 16'd77};
            {ilim, tlim, lo_thr, hi_thr} = {16'd768, 16'd1280, 16'd40000, 16'd20000};
         end
         4: begin   // defaults with a narrow thrust window and a stray top bit on the limits
            {kp_rp, ki_rp, kp_y, ki_y} = {16'd3840, 16'd51, 16'd5120, 16'd77};
            {ilim, tlim, lo_thr, hi_thr} = {16'h8300, 16'h8500, 16'd4096, 16'd61440};
         end
         default: begin
            {kp_rp, ki_rp, kp_y, ki_y} = {16'($urandom), 16'($urandom), 16'($urandom),
                                          16'($urandom)};
            {ilim, tlim, lo_thr, hi_thr} = {16'($urandom), 16'($urandom),
                                            16'($urandom), 16'($urandom)};
         end
      endcase
      write_reg(rpmm_pkg::CSR_KP_RP, kp_rp);
      write_reg(rpmm_pkg::CSR_KI_RP, ki_rp);
      write_reg(rpmm_pkg::CSR_KP_YAW, kp_y);
      write_reg(rpmm_pkg::CSR_KI_YAW, ki_y);
      write_reg(rpmm_pkg::CSR_INT_LIM, ilim);
      write_reg(rpmm_pkg::CSR_TRQ_LIM, tlim);
      write_reg(rpmm_pkg::CSR_FLOOR, lo_thr);
      write_reg(rpmm_pkg::CSR_CEILING, hi_thr);
   endtask

   task automatic queue_cmd(rate_cmd_type c);
      pending_cmds.push_back(c);
      n_queued++;
   endtask

   // every queued tick transferred and answered, then let the pipe settle
   task automatic wait_drained();
      while (n_accepted != n_queued || expected_motors.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed ticks on the reset register values
      @(negedge clock);
      queue_cmd(mk_cmd(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      queue_cmd(mk_cmd(16'hffff, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      // largest error of each sign on each axis in turn
      queue_cmd(mk_cmd(16'd0, 16'h7fff, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0));
      queue_cmd(mk_cmd(16'hffff, 16'h8000, 16'd0, 16'd0, 16'h7fff, 16'd0, 16'd0));
      queue_cmd(mk_cmd(16'd0, 16'd0, 16'h7fff, 16'd0, 16'd0, 16'h8000, 16'd0));
      queue_cmd(mk_cmd(16'hffff, 16'd0, 16'h8000, 16'd0, 16'd0, 16'h7fff, 16'd0));
      queue_cmd(mk_cmd(16'd0, 16'd0, 16'd0, 16'h7fff, 16'd0, 16'd0, 16'h8000));
      queue_cmd(mk_cmd(16'hffff, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 16'h7fff));
      queue_cmd(mk_cmd(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000));
      queue_cmd(mk_cmd(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff));
      // single-lsb errors for the rounding of both signs
      queue_cmd(mk_cmd(16'h8000, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0));
      queue_cmd(mk_cmd(16'h8000, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1));
      queue_cmd(mk_cmd(16'h8000, 16'h1234, 16'hedcc, 16'h0100, 16'h1234, 16'hedcc, 16'h0100));
      // integral stepping into its upper limit, then driven back down
      repeat (4) queue_cmd(mk_cmd(16'h8000, 16'd256, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      repeat (3) queue_cmd(mk_cmd(16'h8000, 16'hfe00, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      wait_drained();

      // random ticks under a series of register settings
      for (int p = 0; p < NUM_PROFILES; p++) begin
         load_profile(p);
         @(negedge clock);
         repeat (ITEMS_PER_PH) queue_cmd(draw_cmd());
         wait_drained();
      end

      $display("covered %0d control ticks over %0d register settings, %0d responses checked",
               n_accepted, NUM_PROFILES + 1, n_checked);
      $display("field mismatches and stray responses: %0d", n_mismatch);
      if (n_mismatch == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/rpmm_pkg.sv
sv/rpmm_integ.sv
sv/rpmm_axis_pid.sv
sv/rpmm_mixer.sv
sv/rate_pid_motor_mixer_unit.sv
sv/rpmm_checker.sv
tb/rate_pid_motor_mixer_unit_tb.sv
